// ===== rtl/series_frequency_upsampler_macros.svh =====
// Assertion shorthands for the frequency upsampler checker.
`ifndef SERIES_FREQUENCY_UPSAMPLER_MACROS_SVH
`define SERIES_FREQUENCY_UPSAMPLER_MACROS_SVH

// same-cycle implication
`define SFU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfu_pkg.sv =====
package sfu_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_RATIO   = 64;
  localparam int RATIO_W     = $clog2(MAX_RATIO + 1);
  localparam int CNT_W       = $clog2(MAX_RATIO);
  localparam int DIFF_W      = VALUE_WIDTH + 1;  // cur - prev, or divider input
  localparam int ACC_W       = VALUE_WIDTH + 2;  // quotients and running sums
  localparam int DIV_CNT_W   = $clog2(DIFF_W);
  localparam int CFG_IDX_W   = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_METHOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KIND   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RATIO  = CFG_IDX_W'(2);

  localparam logic METHOD_LINEAR = 1'b0;
  localparam logic METHOD_STEP   = 1'b1;
  localparam logic KIND_STOCK    = 1'b0;
  localparam logic KIND_FLOW     = 1'b1;

  localparam logic [RATIO_W-1:0] RATIO_MIN   = RATIO_W'(2);
  localparam logic [RATIO_W-1:0] RATIO_MAX   = RATIO_W'(MAX_RATIO);
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(4);

  typedef struct packed {
    logic load;       // input transfer this cycle
    logic div_start;  // launch the divider on the loaded item
    logic step;       // output transfer this cycle
  } sfu_cmd_t;

  typedef struct packed {
    logic need_div;   // offered item needs a quotient
    logic div_done;
    logic last;       // current output closes the group
  } sfu_status_t;

endpackage

// ===== rtl/sfu_div.sv =====
module sfu_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sfu_pkg::DIFF_W-1:0]   dividend,
  input  logic        [sfu_pkg::RATIO_W-1:0]  divisor,
  output logic                                done,
  output logic signed [sfu_pkg::ACC_W-1:0]    q_trunc,
  output logic signed [sfu_pkg::ACC_W-1:0]    q_floor,
  output logic        [sfu_pkg::RATIO_W-1:0]  r_floor
);

  localparam logic [sfu_pkg::DIV_CNT_W-1:0] DIV_LAST =
    sfu_pkg::DIV_CNT_W'(sfu_pkg::DIFF_W - 1);

  logic                             busy;
  logic [sfu_pkg::DIV_CNT_W-1:0]    cnt;
  logic [sfu_pkg::DIFF_W-1:0]       quo;
  logic [sfu_pkg::RATIO_W-1:0]      rem;
  logic [sfu_pkg::RATIO_W-1:0]      dvs;
  logic                             neg;

  logic [sfu_pkg::DIFF_W-1:0]       mag_in;
  logic [sfu_pkg::RATIO_W:0]        trial;
  logic [sfu_pkg::RATIO_W:0]        trial_sub;
  logic                             fits;
  logic [sfu_pkg::RATIO_W-1:0]      rem_next;
  logic [sfu_pkg::ACC_W-1:0]        mag;

  assign mag_in    = dividend[sfu_pkg::DIFF_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial     = {rem, quo[sfu_pkg::DIFF_W-1]};
  assign fits      = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};
  assign rem_next  = fits ? trial_sub[sfu_pkg::RATIO_W-1:0] : trial[sfu_pkg::RATIO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // restoring division of the magnitude, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      quo <= mag_in;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[sfu_pkg::DIFF_W-1];
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      quo <= {quo[sfu_pkg::DIFF_W-2:0], fits};
      rem <= rem_next;
    end
  end

  // sign fixup: truncated and floored forms
  always_comb begin
    mag     = {1'b0, quo};
    q_trunc = neg ? (~mag + 1'b1) : mag;
    if (neg && rem != '0) begin
      q_floor = ~mag;
      r_floor = dvs - rem;
    end else begin
      q_floor = q_trunc;
      r_floor = rem;
    end
  end

endmodule

// ===== rtl/sfu_ctrl.sv =====
module sfu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  input  logic                  m_ready,
  input  sfu_pkg::sfu_status_t  status,
  output logic                  s_ready,
  output logic                  m_valid,
  output sfu_pkg::sfu_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd.load      = (state == ST_IDLE) && s_valid;
    cmd.div_start = cmd.load && status.need_div;
    cmd.step      = (state == ST_EMIT) && m_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      s_ready <= 1'b1;
      m_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            s_ready <= 1'b0;
            if (status.need_div) begin
              state <= ST_DIV;
            end else begin
              state   <= ST_EMIT;
              m_valid <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (status.div_done) begin
            state   <= ST_EMIT;
            m_valid <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (cmd.step && status.last) begin
            state   <= ST_IDLE;
            m_valid <= 1'b0;
            s_ready <= 1'b1;
          end
        end
        default: begin
          state   <= ST_IDLE;
          m_valid <= 1'b0;
          s_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sfu_dpath.sv =====
module sfu_dpath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic        [sfu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [sfu_pkg::RATIO_W-1:0]      cfg_data,
  input  logic signed [sfu_pkg::VALUE_WIDTH-1:0]  in_value,
  input  logic                                    in_present,
  input  logic                                    in_end,
  input  sfu_pkg::sfu_cmd_t                       cmd,
  output sfu_pkg::sfu_status_t                    status,
  output logic signed [sfu_pkg::VALUE_WIDTH-1:0]  out_value,
  output logic                                    out_present,
  output logic                                    out_last
);

  localparam logic signed [sfu_pkg::ACC_W-1:0] ACC_ONE = sfu_pkg::ACC_W'(1);

  // configuration
  logic                             method;
  logic                             kind;
  logic [sfu_pkg::RATIO_W-1:0]      ratio;

  // series state
  logic signed [sfu_pkg::VALUE_WIDTH-1:0] prev_value;
  logic                                   prev_present;

  // per-item registers
  logic signed [sfu_pkg::VALUE_WIDTH-1:0] cur;
  logic signed [sfu_pkg::VALUE_WIDTH-1:0] base_prev;
  logic                                   ok;
  logic                                   flow;
  logic                                   step_mode;
  logic [sfu_pkg::RATIO_W-1:0]            r;
  logic [sfu_pkg::CNT_W-1:0]              j;

  // running floor((j+1)*d/r) as acc + rsd/r
  logic signed [sfu_pkg::ACC_W-1:0]       acc;
  logic [sfu_pkg::RATIO_W-1:0]            rsd;
  logic signed [sfu_pkg::ACC_W-1:0]       qd;
  logic [sfu_pkg::RATIO_W-1:0]            rd;
  logic signed [sfu_pkg::ACC_W-1:0]       qtr;

  logic [sfu_pkg::RATIO_W-1:0]            r_clamp;
  logic signed [sfu_pkg::DIFF_W-1:0]      cur_ext;
  logic signed [sfu_pkg::DIFF_W-1:0]      prev_ext;
  logic signed [sfu_pkg::DIFF_W-1:0]      dividend;
  logic                                   div_done;
  logic signed [sfu_pkg::ACC_W-1:0]       div_qt;
  logic signed [sfu_pkg::ACC_W-1:0]       div_qf;
  logic [sfu_pkg::RATIO_W-1:0]            div_rf;
  logic [sfu_pkg::RATIO_W:0]              rsum;
  logic [sfu_pkg::RATIO_W:0]              rsum_sub;
  logic                                   wrap;
  logic signed [sfu_pkg::ACC_W-1:0]       base;
  logic signed [sfu_pkg::ACC_W-1:0]       lin;

  always_comb begin
    if (ratio < sfu_pkg::RATIO_MIN) begin
      r_clamp = sfu_pkg::RATIO_MIN;
    end else if (ratio > sfu_pkg::RATIO_MAX) begin
      r_clamp = sfu_pkg::RATIO_MAX;
    end else begin
      r_clamp = ratio;
    end
  end

  assign cur_ext  = sfu_pkg::DIFF_W'(in_value);
  assign prev_ext = sfu_pkg::DIFF_W'(prev_value);
  assign dividend = (kind == sfu_pkg::KIND_FLOW) ? cur_ext : (cur_ext - prev_ext);

  assign status.need_div = in_present &&
                           ((kind == sfu_pkg::KIND_FLOW) ||
                            (method == sfu_pkg::METHOD_LINEAR && prev_present));
  assign status.div_done = div_done;
  assign status.last     = {1'b0, j} == (r - 1'b1);

  sfu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (r_clamp),
    .done     (div_done),
    .q_trunc  (div_qt),
    .q_floor  (div_qf),
    .r_floor  (div_rf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      method       <= sfu_pkg::METHOD_LINEAR;
      kind         <= sfu_pkg::KIND_STOCK;
      ratio        <= sfu_pkg::RATIO_RESET;
      prev_value   <= '0;
      prev_present <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sfu_pkg::REG_METHOD: method <= cfg_data[0];
          sfu_pkg::REG_KIND:   kind   <= cfg_data[0];
          sfu_pkg::REG_RATIO:  ratio  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (in_end) begin
          prev_value   <= '0;
          prev_present <= 1'b0;
        end else begin
          prev_value   <= in_value;
          prev_present <= in_present;
        end
      end
    end
  end

  assign rsum     = {1'b0, rsd} + {1'b0, rd};
  assign rsum_sub = rsum - {1'b0, r};
  assign wrap     = rsum >= {1'b0, r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur       <= in_value;
      base_prev <= prev_value;
      ok        <= in_present && ((kind == sfu_pkg::KIND_FLOW) ||
                                  (method == sfu_pkg::METHOD_STEP) || prev_present);
      flow      <= kind == sfu_pkg::KIND_FLOW;
      step_mode <= method == sfu_pkg::METHOD_STEP;
      r         <= r_clamp;
      j         <= '0;
    end else if (cmd.step) begin
      j <= j + 1'b1;
    end

    if (div_done) begin
      acc <= div_qf;
      rsd <= div_rf;
      qd  <= div_qf;
      rd  <= div_rf;
      qtr <= div_qt;
    end else if (cmd.step) begin
      acc <= acc + qd + (wrap ? ACC_ONE : '0);
      rsd <= wrap ? rsum_sub[sfu_pkg::RATIO_W-1:0] : rsum[sfu_pkg::RATIO_W-1:0];
    end
  end

  // prev + floor part, bumped toward zero when negative with a fraction left
  assign base = sfu_pkg::ACC_W'(base_prev) + acc;
  assign lin  = (base < 0 && rsd != '0) ? base + ACC_ONE : base;

  always_comb begin
    if (!ok) begin
      out_value = '0;
    end else if (flow) begin
      out_value = qtr[sfu_pkg::VALUE_WIDTH-1:0];
    end else if (step_mode) begin
      out_value = cur;
    end else begin
      out_value = lin[sfu_pkg::VALUE_WIDTH-1:0];
    end
  end

  assign out_present = ok;
  assign out_last    = status.last;

endmodule

// ===== rtl/series_frequency_upsampler.sv =====
// Each accepted sample yields ratio outputs (ratio clamped to 2..64), one per cycle
// while m_axis_tready is high. Flow items with the sample present and linear stock
// items with both samples present go through the 33-bit bit-serial divider before
// their first output. Other items: first output the cycle after the transfer. One item
// in flight at a time: a new input is taken only after the group's last output.
// Synchronous reset: idle, linear stock with ratio 4, previous sample cleared.
module series_frequency_upsampler (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic        [sfu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [sfu_pkg::RATIO_W-1:0]      cfg_data,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic signed [sfu_pkg::VALUE_WIDTH-1:0]  s_axis_tdata,   // sample_value
  input  logic                                    s_axis_tuser,   // sample_present
  input  logic                                    s_axis_tlast,   // series_end
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic signed [sfu_pkg::VALUE_WIDTH-1:0]  m_axis_tdata,   // out_value
  output logic                                    m_axis_tuser,   // out_present
  output logic                                    m_axis_tlast    // last_of_group
);

  sfu_pkg::sfu_cmd_t    cmd;
  sfu_pkg::sfu_status_t status;

  sfu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .m_ready (m_axis_tready),
    .status  (status),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .cmd     (cmd)
  );

  sfu_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_value    (s_axis_tdata),
    .in_present  (s_axis_tuser),
    .in_end      (s_axis_tlast),
    .cmd         (cmd),
    .status      (status),
    .out_value   (m_axis_tdata),
    .out_present (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

endmodule

// ===== rtl/sfu_checker.sv =====
`include "series_frequency_upsampler_macros.svh"

module sfu_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    s_axis_tvalid,
  input logic                                    s_axis_tready,
  input logic                                    m_axis_tvalid,
  input logic                                    m_axis_tready,
  input logic signed [sfu_pkg::VALUE_WIDTH-1:0]  m_axis_tdata,
  input logic                                    m_axis_tuser,
  input logic                                    m_axis_tlast
);

  // one item in flight: never open for input while a group is out
  `SFU_ASSERT_IMP(a_one_item, clk, rst, s_axis_tready, !m_axis_tvalid, "input open during output")
  `SFU_ASSERT_NXT(a_in_closes, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input stayed open")
  `SFU_ASSERT_NXT(a_group_ends, clk, rst, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "output past group end")
  `SFU_ASSERT_IMP(a_missing_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "missing output not zero")
  `SFU_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output valid dropped")

endmodule

bind series_frequency_upsampler sfu_checker u_sfu_checker (.*);

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfu_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 120;
  localparam int MAX_PRINTED     = 40;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 30;

  // index past the register list, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;
  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_index;
    logic [RATIO_W-1:0]      reg_data;
    logic [VALUE_WIDTH-1:0]  value;
    logic                    present;
    logic                    ends;
    logic                    known;      // group value typed in below
    logic [VALUE_WIDTH-1:0]  known_value;
    logic                    known_present;
  } stim_row_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]  value;
    logic                    present;
    logic                    last;
  } hf_sample_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic        [CFG_IDX_W-1:0]    cfg_index = '0;
  logic        [RATIO_W-1:0]      cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic signed [VALUE_WIDTH-1:0]  s_axis_tdata = '0;   // sample_value
  logic                           s_axis_tuser = 1'b0; // sample_present
  logic                           s_axis_tlast = 1'b0; // series_end
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic signed [VALUE_WIDTH-1:0]  m_axis_tdata;        // out_value
  logic                           m_axis_tuser;        // out_present
  logic                           m_axis_tlast;        // last_of_group

  series_frequency_upsampler u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // shadow of the configuration and of the stored previous sample
  logic                    method_reg = METHOD_LINEAR;
  logic                    kind_reg = KIND_STOCK;
  logic [RATIO_W-1:0]      ratio_reg = RATIO_RESET;
  logic [VALUE_WIDTH-1:0]  prev_value = '0;
  logic                    prev_present = 1'b0;

  hf_sample_t  hf_expected[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  rx_mode_t    rx_mode = RX_STEADY;
  int          rx_mode_left = 0;
  int          rx_phase = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d samples still expected",
               cycle_count, hf_expected.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED)
      $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Expected high-frequency samples for one accepted low-frequency sample.
  function automatic void upsample_group(input logic [VALUE_WIDTH-1:0] value,
                                         input logic present, input logic ends,
                                         input logic known,
                                         input logic [VALUE_WIDTH-1:0] known_value,
                                         input logic known_present);
    hf_sample_t s;
    int         r;
    int         j;
    logic       ok;
    longint     cur;
    longint     prev;
    longint     num;
    r = int'(ratio_reg);
    if (r < 2)
      r = 2;
    if (r > MAX_RATIO)
      r = MAX_RATIO;
    cur = longint'($signed(value));
    prev = longint'($signed(prev_value));
    if (kind_reg == KIND_FLOW || method_reg == METHOD_STEP)
      ok = present;
    else
      ok = present && prev_present;
    for (j = 0; j < r; j++) begin
      s.last = (j == r - 1);
      s.present = ok;
      if (!ok) begin
        s.value = '0;
      end else if (kind_reg == KIND_FLOW) begin
        s.value = VALUE_WIDTH'(cur / longint'(r));
      end else if (method_reg == METHOD_STEP || s.last) begin
        s.value = value;
      end else begin
        // weights sum to r, so the blend stays within range; / truncates toward zero
        num = longint'(r - 1 - j) * prev + longint'(j + 1) * cur;
        s.value = VALUE_WIDTH'(num / longint'(r));
      end
      if (known) begin
        s.value = known_value;
        s.present = known_present;
      end
      hf_expected.push_back(s);
    end
    if (ends) begin
      prev_value = '0;
      prev_present = 1'b0;
    end else begin
      prev_value = value;
      prev_present = present;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_METHOD: method_reg = data[0];
      REG_KIND:   kind_reg = data[0];
      REG_RATIO:  ratio_reg = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (hf_expected.size() != 0)
      @(posedge clk);
  endtask

  task automatic send_sample(input logic [VALUE_WIDTH-1:0] value, input logic present,
                             input logic ends, input logic known,
                             input logic [VALUE_WIDTH-1:0] known_value,
                             input logic known_present);
    int gap;
    cfg_we <= 1'b0;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    s_axis_tuser <= present;
    s_axis_tlast <= ends;
    do
      @(posedge clk);
    while (!s_axis_tready);
    upsample_group(value, present, ends, known, known_value, known_present);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 5) == 0) begin
        gap = 0;
        burst_left = 40;
      end else begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
        burst_left = $urandom_range(0, 8);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [RATIO_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_index = idx;
    row.reg_data = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_sample(input logic [VALUE_WIDTH-1:0] value,
                                     input logic present, input logic ends);
    stim_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.value = value;
    row.present = present;
    row.ends = ends;
    directed_rows.push_back(row);
  endfunction

  // sample whose whole group has one value that is obvious from the row
  function automatic void add_known(input logic [VALUE_WIDTH-1:0] value,
                                    input logic present, input logic ends,
                                    input logic [VALUE_WIDTH-1:0] known_value,
                                    input logic known_present);
    stim_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.value = value;
    row.present = present;
    row.ends = ends;
    row.known = 1'b1;
    row.known_value = known_value;
    row.known_present = known_present;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] random_sample_value();
    int v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = int'($urandom_range(0, 600)) - 300;
      3: v = int'($urandom_range(0, 2)) - 1;
      default: v = $urandom;
    endcase
    return VALUE_WIDTH'(v);
  endfunction

  // Receiver: changes its stall pattern now and then; serves long hold-off requests.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 128);
      end
      rx_mode_left--;
      rx_phase = (rx_phase == 4) ? 0 : rx_phase + 1;
      case (rx_mode)
        RX_STEADY:   m_axis_tready <= 1'b1;
        RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: m_axis_tready <= (rx_phase >= 2);
        default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // output checker
  always @(posedge clk) begin
    hf_sample_t exp_s;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (hf_expected.size() == 0) begin
        report_mismatch($sformatf("output transfer with nothing expected: value %h",
                                  m_axis_tdata));
      end else begin
        exp_s = hf_expected.pop_front();
        if (m_axis_tdata !== exp_s.value)
          report_mismatch($sformatf("out_value %h, expected %h", m_axis_tdata, exp_s.value));
        if (m_axis_tuser !== exp_s.present)
          report_mismatch($sformatf("out_present %b, expected %b",
                                    m_axis_tuser, exp_s.present));
        if (m_axis_tlast !== exp_s.last)
          report_mismatch($sformatf("last_of_group %b, expected %b",
                                    m_axis_tlast, exp_s.last));
      end
    end
  end

  initial begin
    stim_row_t row;
    int        phase;
    int        n;
    int        series_left;
    logic      present;
    logic      ends;
    logic [RATIO_W-1:0] ratio_pick;

    // reset config: linear stock, ratio 4
    add_known(32'h0001_0000, 1'b1, 1'b0, '0, 1'b0);   // no previous after reset
    add_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    add_sample(32'h8000_0000, 1'b1, 1'b0);
    add_known(32'h0000_0005, 1'b0, 1'b0, '0, 1'b0);   // current missing
    add_known(32'hFFFF_FFF9, 1'b1, 1'b0, '0, 1'b0);   // previous missing
    add_sample(32'hFFFF_FFF9, 1'b1, 1'b1);
    add_known(32'h0000_0003, 1'b1, 1'b0, '0, 1'b0);   // new series after end
    add_sample(32'hFFFF_FFFD, 1'b1, 1'b0);           // blend crosses zero
    add_write(REG_METHOD, RATIO_W'(METHOD_STEP));
    add_known(32'h7FFF_FFFF, 1'b1, 1'b0, 32'h7FFF_FFFF, 1'b1);
    add_known(32'h8000_0000, 1'b0, 1'b0, '0, 1'b0);
    add_known(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
    add_write(REG_KIND, RATIO_W'(KIND_FLOW));
    add_known(32'h8000_0000, 1'b1, 1'b0, 32'hE000_0000, 1'b1);
    add_sample(32'hFFFF_FFFB, 1'b1, 1'b0);
    add_known(32'h0000_0007, 1'b0, 1'b0, '0, 1'b0);
    add_write(REG_METHOD, RATIO_W'(METHOD_LINEAR));
    add_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    add_sample(32'hFFFF_FFFD, 1'b1, 1'b1);
    add_write(REG_RATIO, RATIO_W'(0));               // clamps up to 2
    add_sample(32'h0000_0064, 1'b1, 1'b0);
    add_write(REG_RATIO, RATIO_W'(1));
    add_sample(32'hFFFF_FF9C, 1'b1, 1'b0);
    add_write(REG_RATIO, RATIO_W'(127));             // clamps down to MAX_RATIO
    add_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    add_write(REG_KIND, RATIO_W'(KIND_STOCK));
    add_sample(32'h8000_0000, 1'b1, 1'b0);
    add_sample(32'h7FFF_FFFF, 1'b1, 1'b1);
    add_write(REG_UNUSED, RATIO_W'(127));
    add_write(REG_RATIO, RATIO_W'(MAX_RATIO));
    add_known(32'h0000_3039, 1'b1, 1'b0, '0, 1'b0);
    add_sample(32'hFFFF_CFC7, 1'b1, 1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained();
        write_reg(row.reg_index, row.reg_data);
      end else begin
        send_sample(row.value, row.present, row.ends, row.known,
                    row.known_value, row.known_present);
      end
    end

    series_left = 0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        3:       ratio_pick = RATIO_W'(MAX_RATIO);
        6:       ratio_pick = RATIO_W'($urandom_range(MAX_RATIO + 1, 127));
        9:       ratio_pick = RATIO_W'($urandom_range(0, 1));
        11:      ratio_pick = RATIO_MIN;
        default: ratio_pick = RATIO_W'($urandom_range(2, 16));
      endcase
      wait_drained();
      write_reg(REG_METHOD, RATIO_W'(phase % 2));
      write_reg(REG_KIND, RATIO_W'((phase / 2) % 2));
      write_reg(REG_RATIO, ratio_pick);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 2 && n == 8)
          hold_requests++;
        if (series_left == 0)
          series_left = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) begin
          // noise: random flags regardless of the series in progress
          present = $urandom_range(0, 1);
          ends = $urandom_range(0, 1);
        end else begin
          present = ($urandom_range(0, 11) != 0);
          ends = (series_left == 1);
        end
        series_left--;
        send_sample(random_sample_value(), present, ends, 1'b0, '0, 1'b0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && hf_expected.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== series_frequency_upsampler.f =====
+incdir+rtl
rtl/sfu_pkg.sv
rtl/sfu_div.sv
rtl/sfu_ctrl.sv
rtl/sfu_dpath.sv
rtl/series_frequency_upsampler.sv
rtl/sfu_checker.sv
test/testbench.sv
